### src/bgp_pkg.sv
package bgp_pkg;

  // One request as it arrives on the input channel.
  typedef struct packed {
    logic        req_type;
    logic [31:0] branch_pc;
    logic [1:0]  thread_index;
    logic        predicted_dir;
    logic        resolved_dir;
  } bgp_req_t;

  // One result as it leaves on the output channel.
  typedef struct packed {
    logic        predict_taken;
    logic [31:0] correct_count;
    logic [31:0] mispredict_count;
  } bgp_rsp_t;

  // A classified request waiting between the front and the back.
  typedef struct packed {
    bgp_req_t    req;
    logic [1:0]  mode;
    logic [4:0]  idx_width;
    logic [3:0]  thread;
  } bgp_job_t;

  localparam logic [1:0] MODE_NOT_TAKEN = 2'd0;
  localparam logic [1:0] MODE_TAKEN     = 2'd1;
  localparam logic [1:0] MODE_BIMODAL   = 2'd2;
  localparam logic [1:0] MODE_GSHARE    = 2'd3;

  localparam logic REQ_PREDICT = 1'b0;
  localparam logic REQ_UPDATE  = 1'b1;

  localparam logic REG_MODE       = 1'b0;
  localparam logic REG_INDEX_BITS = 1'b1;

  localparam logic [1:0] MODE_RESET       = MODE_GSHARE;
  localparam logic [3:0] INDEX_BITS_RESET = 4'd12;

  localparam logic [1:0] CTR_MAX  = 2'd3;
  localparam logic [1:0] CTR_MIN  = 2'd0;
  localparam logic [1:0] CTR_INIT = 2'd2;

endpackage

### src/bgp_ram.sv
module bgp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/bgp_front.sv
module bgp_front #(
  parameter int INDEX_BITS = 12,
  parameter int THREADS    = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              clearing,
  output logic              busy,
  input  bgp_pkg::bgp_req_t request,
  input  logic [1:0]        predictor_mode,
  input  logic [3:0]        index_bits,
  output logic              job_valid,
  input  logic              job_ready,
  output bgp_pkg::bgp_job_t job
);

  localparam logic [4:0] MAX_WIDTH = 5'(INDEX_BITS);
  localparam logic [4:0] THR       = 5'(THREADS);

  bgp_pkg::bgp_job_t slots [2];
  bgp_pkg::bgp_job_t job_in;
  logic [1:0] count;
  logic       wr_ptr;
  logic       rd_ptr;
  logic       push;
  logic       pop;
  logic [4:0] width_c;
  logic [4:0] thr_c;

  // Clamp the index width and fold the thread number into range.
  always_comb begin
    width_c = {1'b0, index_bits};
    if (width_c == 5'd0) begin
      width_c = 5'd1;
    end
    if (width_c > MAX_WIDTH) begin
      width_c = MAX_WIDTH;
    end
    thr_c = {3'b000, request.thread_index};
    for (int k = 0; k < 3; k++) begin
      if (thr_c >= THR) begin
        thr_c = thr_c - THR;
      end
    end
    job_in.req       = request;
    job_in.mode      = predictor_mode;
    job_in.idx_width = width_c;
    job_in.thread    = thr_c[3:0];
  end

  assign busy      = clearing || (count == 2'd2);
  assign push      = start && !busy;
  assign job_valid = (count != 2'd0);
  assign pop       = job_valid && job_ready;
  assign job       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= job_in;
    end
  end

endmodule

### src/bgp_back.sv
module bgp_back #(
  parameter int INDEX_BITS = 12,
  parameter int THREADS    = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  bgp_pkg::bgp_job_t job,
  output logic              job_ready,
  output logic              clearing,
  output logic              done,
  output bgp_pkg::bgp_rsp_t result
);

  localparam int TID_W = (THREADS > 1) ? $clog2(THREADS) : 1;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]            state;
  logic [INDEX_BITS-1:0] clr_addr;
  logic [INDEX_BITS-1:0] history [THREADS];
  logic [31:0]           correct_total;
  logic [31:0]           mispredict_total;

  bgp_pkg::bgp_job_t     cur_job;
  logic [INDEX_BITS-1:0] cur_idx;
  logic [TID_W-1:0]      cur_tid;

  logic [TID_W-1:0]      tid;
  logic [INDEX_BITS-1:0] mask;
  logic [INDEX_BITS-1:0] idx;
  logic [1:0]            ctr;
  logic [1:0]            ctr_next;
  logic                  pred;
  logic                  is_update;
  logic                  table_mode;
  logic                  ram_we;
  logic [INDEX_BITS-1:0] ram_waddr;
  logic [1:0]            ram_wdata;
  logic [31:0]           correct_next;
  logic [31:0]           mispredict_next;

  assign clearing  = (state == S_CLEAR);
  assign job_ready = (state == S_IDLE);
  assign tid       = job.thread[TID_W-1:0];

  // Index of the job at the head of the queue, from the current history.
  always_comb begin
    for (int i = 0; i < INDEX_BITS; i++) begin
      mask[i] = (5'(i) < job.idx_width);
    end
    if (job.mode == bgp_pkg::MODE_GSHARE) begin
      idx = (job.req.branch_pc[INDEX_BITS-1:0] ^ history[tid]) & mask;
    end else begin
      idx = job.req.branch_pc[INDEX_BITS-1:0] & mask;
    end
  end

  // Predict and train from the counter read in the previous cycle.
  always_comb begin
    is_update  = (cur_job.req.req_type == bgp_pkg::REQ_UPDATE);
    table_mode = (cur_job.mode == bgp_pkg::MODE_BIMODAL) ||
                 (cur_job.mode == bgp_pkg::MODE_GSHARE);
    unique case (cur_job.mode)
      bgp_pkg::MODE_NOT_TAKEN: pred = 1'b0;
      bgp_pkg::MODE_TAKEN:     pred = 1'b1;
      default:                 pred = ctr[1];
    endcase
    if (cur_job.req.resolved_dir) begin
      ctr_next = (ctr == bgp_pkg::CTR_MAX) ? bgp_pkg::CTR_MAX : ctr + 2'd1;
    end else begin
      ctr_next = (ctr == bgp_pkg::CTR_MIN) ? bgp_pkg::CTR_MIN : ctr - 2'd1;
    end
    correct_next    = correct_total;
    mispredict_next = mispredict_total;
    if (is_update) begin
      if (cur_job.req.predicted_dir == cur_job.req.resolved_dir) begin
        correct_next = correct_total + 32'd1;
      end else begin
        mispredict_next = mispredict_total + 32'd1;
      end
    end
  end

  always_comb begin
    if (clearing) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = bgp_pkg::CTR_INIT;
    end else begin
      ram_we    = (state == S_EXEC) && is_update && table_mode;
      ram_waddr = cur_idx;
      ram_wdata = ctr_next;
    end
  end

  bgp_ram #(
    .WIDTH (2),
    .DEPTH (1 << INDEX_BITS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ctr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      clr_addr         <= '0;
      correct_total    <= 32'd0;
      mispredict_total <= 32'd0;
      done             <= 1'b0;
      for (int t = 0; t < THREADS; t++) begin
        history[t] <= '0;
      end
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + INDEX_BITS'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (job_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          correct_total    <= correct_next;
          mispredict_total <= mispredict_next;
          if (is_update && (cur_job.mode == bgp_pkg::MODE_GSHARE)) begin
            history[cur_tid] <= INDEX_BITS'({history[cur_tid], cur_job.req.resolved_dir});
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_IDLE) && job_valid) begin
      cur_job <= job;
      cur_idx <= idx;
      cur_tid <= tid;
    end
    if (state == S_EXEC) begin
      result.predict_taken    <= pred;
      result.correct_count    <= correct_next;
      result.mispredict_count <= mispredict_next;
    end
  end

endmodule

### src/bimodal_gshare_branch_predictor.sv
// Branch direction predictor: 2-bit saturating counters, four modes
// (always not-taken, always taken, bimodal, gshare with per-thread history).
//
// Request channel: drive request and raise start; the transaction is taken at
// the rising edge where start is high and busy is low. Every transaction,
// predict or update, yields exactly one result: done is high for one cycle
// and result holds the prediction (read before any training by the same
// transaction) and both 32-bit outcome counts after it.
// Configuration: wr_en with wr_index 0 writes predictor_mode, 1 writes
// index_bits, from wr_data; write only while no transaction is in flight.
//
// Sequence: the accepting edge writes the queue; the back end then takes the
// job and reads its counter, then trains and registers result and done. It
// takes a new transaction only once the last is done, set by its read-then-write
// sequence on the counter table: each read must see the previous transaction's write.
// A two-entry queue between front and back absorbs requests; busy rises when it fills.
// Reset: synchronous; afterwards busy stays high while all 2**INDEX_BITS entries
// (4096 by default) of the table are swept to weakly taken. The receiver
// cannot stall: done marks a result for one cycle only.
module bimodal_gshare_branch_predictor #(
  parameter int INDEX_BITS = 12,
  parameter int THREADS    = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  bgp_pkg::bgp_req_t request,
  input  logic              wr_en,
  input  logic              wr_index,
  input  logic [3:0]        wr_data,
  output logic              done,
  output bgp_pkg::bgp_rsp_t result
);

  logic [1:0]        predictor_mode;
  logic [3:0]        index_bits;
  logic              clearing;
  logic              job_valid;
  logic              job_ready;
  bgp_pkg::bgp_job_t job;

  // Configuration registers; hold until rewritten.
  always_ff @(posedge clk) begin
    if (rst) begin
      predictor_mode <= bgp_pkg::MODE_RESET;
      index_bits     <= bgp_pkg::INDEX_BITS_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        bgp_pkg::REG_MODE:       predictor_mode <= wr_data[1:0];
        bgp_pkg::REG_INDEX_BITS: index_bits     <= wr_data;
        default:                 predictor_mode <= predictor_mode;
      endcase
    end
  end

  // Front: accept, clamp the index width, fold the thread, enqueue.
  bgp_front #(
    .INDEX_BITS (INDEX_BITS),
    .THREADS    (THREADS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .clearing       (clearing),
    .busy           (busy),
    .request        (request),
    .predictor_mode (predictor_mode),
    .index_bits     (index_bits),
    .job_valid      (job_valid),
    .job_ready      (job_ready),
    .job            (job)
  );

  // Back: read the counter, predict, train, advance history and counts.
  bgp_back #(
    .INDEX_BITS (INDEX_BITS),
    .THREADS    (THREADS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_ready (job_ready),
    .clearing  (clearing),
    .done      (done),
    .result    (result)
  );

endmodule

### src/bgp_checker.sv
module bgp_checker (
  input logic clk,
  input logic rst,
  input logic busy,
  input logic done
);

  // The table sweep after reset keeps the request channel closed.
  a_busy_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("busy low right after reset");

  // No result is left over from before reset.
  a_no_done_after_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  // The back end returns to idle after each result, so done never repeats back to back.
  a_done_spacing: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("results on consecutive cycles");

endmodule

bind bimodal_gshare_branch_predictor bgp_checker u_bgp_checker (
  .clk   (clk),
  .rst   (rst),
  .busy  (busy),
  .done  (done)
);
